// ===== rtl/dam_pkg.sv =====
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types, codes and constants for the decimal accumulator machine.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int MemWordsDefault = 100;
  localparam int AddrW           = 7;
  localparam int DataW           = 32;
  localparam int OpW             = 6;

  // Input commands
  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdExec  = 2'd1;
  localparam logic [1:0] CmdStart = 2'd2;

  // Opcodes (instruction word / 100)
  localparam logic [OpW-1:0] OpRead   = 6'd10;
  localparam logic [OpW-1:0] OpPrint  = 6'd11;
  localparam logic [OpW-1:0] OpLoad   = 6'd20;
  localparam logic [OpW-1:0] OpStore  = 6'd21;
  localparam logic [OpW-1:0] OpAdd    = 6'd30;
  localparam logic [OpW-1:0] OpSub    = 6'd31;
  localparam logic [OpW-1:0] OpDiv    = 6'd32;
  localparam logic [OpW-1:0] OpMul    = 6'd33;
  localparam logic [OpW-1:0] OpBranch = 6'd40;
  localparam logic [OpW-1:0] OpBrNeg  = 6'd41;
  localparam logic [OpW-1:0] OpBrZero = 6'd42;
  localparam logic [OpW-1:0] OpHalt   = 6'd43;

  // Result status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StPrint   = 3'd1;
  localparam logic [2:0] StHalt    = 3'd2;
  localparam logic [2:0] StDivZero = 3'd3;
  localparam logic [2:0] StBadOp   = 3'd4;
  localparam logic [2:0] StLoaded  = 3'd5;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [AddrW-1:0]        address;
    logic signed [DataW-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [DataW-1:0] print_value;
    logic                    input_used;
    logic [AddrW-1:0]        program_counter;
    logic signed [DataW-1:0] acc_value;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/dam_stream_if.sv =====
// ----------------------------------------------------------------------------
// dam_stream_if
// Valid/ready stream channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface dam_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dam_mem.sv =====
// ----------------------------------------------------------------------------
// dam_mem
// Main word memory: one write and one registered read port per cycle.
// Per-word valid bits make unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module dam_mem #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dam_pkg::mem_req_t       req_i,
  output logic [dam_pkg::DataW-1:0] rdata_o
);
  import dam_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [DataW-1:0]     mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;
  logic [DataW-1:0]     rd_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr[AW-1:0]] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr[AW-1:0]];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

// ===== rtl/dam_div.sv =====
// ----------------------------------------------------------------------------
// dam_div
// Signed 32-bit divider, truncating toward zero. Restoring radix-2,
// one quotient bit per cycle on the operand magnitudes.
// ----------------------------------------------------------------------------
module dam_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [dam_pkg::DataW-1:0] dividend_i,
  input  logic [dam_pkg::DataW-1:0] divisor_i,
  output logic                     done_o,
  output logic [dam_pkg::DataW-1:0] quotient_o
);
  import dam_pkg::*;

  localparam int CntW = $clog2(DataW + 1);

  logic             busy_q, done_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rem_q, quo_q, dvs_q;
  logic [DataW:0]   rem_sh, diff;
  logic             fit;

  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fit    = !diff[DataW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DataW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
      quo_q <= dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_q <= divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? diff[DataW-1:0] : rem_sh[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], fit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ===== rtl/decimal_accumulator_machine.sv =====
// ----------------------------------------------------------------------------
// decimal_accumulator_machine
// Accumulator machine with decimal instruction words (opcode = word / 100,
// operand address = word % 100), program and data in one word memory.
// ----------------------------------------------------------------------------
// One item is in flight at a time; every item gives one result. A load,
// start or halted execute goes to the output state and then to the output
// register. An executed instruction passes through instruction fetch,
// decode, operand read and execute; fetch and operand read each wait on the
// registered memory read. Divide waits on the bit-serial divider. A new item
// is accepted while the previous result still waits in the output register.
// Memory words read as zero until written after reset; no clearing pass.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dam_pkg::AddrW-1:0]  cfg_wdata_i,
  dam_stream_if.sink                 in_i,
  dam_stream_if.source               out_o
);
  import dam_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_OPER = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] start_addr_q;
  logic [AW-1:0]    pc_q, pc_d, pc_inc;
  logic [DataW-1:0] acc_q, acc_d;
  logic             halted_q, halted_d;

  logic [DataW-1:0] data_q;
  logic [OpW-1:0]   op_q;
  logic [12:0]      wlo_q;
  logic             bad_q;
  logic [AW-1:0]    loc_q;

  logic [2:0]       res_status_q, res_status_d;
  logic [DataW-1:0] res_print_q, res_print_d;
  logic             res_used_q, res_used_d;

  logic             out_valid_q;
  out_item_t        out_q;

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;

  logic             div_start, div_done;
  logic [DataW-1:0] div_q;

  logic             in_fire;
  logic             out_free;

  // Address wrap table: value modulo memory size for any 7-bit address
  logic [AW-1:0] wrap_tbl [2**AddrW];
  for (genvar g = 0; g < 2**AddrW; g++) begin : g_wrap
    assign wrap_tbl[g] = AW'(g % MEM_WORDS);
  end

  // Decode of the fetched word: valid opcodes need a word in 1000..4399
  logic [DataW-1:0] w;
  logic             w_in_rng;
  logic [25:0]      w_prod;
  logic [OpW-1:0]   w_op;
  logic             w_op_ok;
  logic [12:0]      rem13;

  assign w        = mem_rdata;
  assign w_in_rng = !w[DataW-1] && (w >= 32'd1000) && (w < 32'd4400);
  // w / 100 by reciprocal, exact for w below 6400
  assign w_prod   = 26'(w[12:0]) * 26'd5243;
  assign w_op     = w_prod[24:19];
  assign rem13    = wlo_q - (13'(op_q) * 13'd100);

  always_comb begin
    w_op_ok = w_op inside {OpRead, OpPrint, OpLoad, OpStore, OpAdd, OpSub, OpDiv,
                           OpMul, OpBranch, OpBrNeg, OpBrZero, OpHalt};
  end

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign pc_inc   = (pc_q == AW'(MEM_WORDS - 1)) ? '0 : pc_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    acc_d        = acc_q;
    halted_d     = halted_q;
    res_status_d = res_status_q;
    res_print_d  = res_print_q;
    res_used_d   = res_used_q;
    mem_req      = '0;
    div_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = StOk;
          res_print_d  = '0;
          res_used_d   = 1'b0;
          state_d      = S_OUT;
          case (in_i.data.cmd)
            CmdLoad: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = AddrW'(wrap_tbl[in_i.data.address]);
              mem_req.wdata = in_i.data.data_word;
              res_status_d  = StLoaded;
            end
            CmdStart: begin
              pc_d     = wrap_tbl[start_addr_q];
              acc_d    = '0;
              halted_d = 1'b0;
            end
            CmdExec: begin
              if (halted_q) begin
                res_status_d = StHalt;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = AddrW'(pc_q);
                state_d       = S_DEC;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEC: begin
        state_d = S_OPER;
      end
      S_OPER: begin
        if (bad_q) begin
          res_status_d = StBadOp;
          state_d      = S_OUT;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AddrW'(wrap_tbl[rem13[AddrW-1:0]]);
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        pc_d    = pc_inc;
        case (op_q)
          OpRead: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AddrW'(loc_q);
            mem_req.wdata = data_q;
            res_used_d    = 1'b1;
          end
          OpPrint: begin
            res_print_d  = mem_rdata;
            res_status_d = StPrint;
          end
          OpLoad:  acc_d = mem_rdata;
          OpStore: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AddrW'(loc_q);
            mem_req.wdata = acc_q;
          end
          OpAdd: acc_d = acc_q + mem_rdata;
          OpSub: acc_d = acc_q - mem_rdata;
          OpDiv: begin
            if (mem_rdata == '0) begin
              res_status_d = StDivZero;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OpMul:    acc_d = DataW'(acc_q * mem_rdata);
          OpBranch: pc_d  = loc_q;
          OpBrNeg:  pc_d  = acc_q[DataW-1] ? loc_q : pc_inc;
          OpBrZero: pc_d  = (acc_q == '0) ? loc_q : pc_inc;
          OpHalt: begin
            pc_d         = pc_q;
            halted_d     = 1'b1;
            res_status_d = StHalt;
          end
          default: begin
            pc_d         = pc_q;
            res_status_d = StBadOp;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          acc_d   = div_q;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_addr_q <= '0;
      pc_q         <= '0;
      acc_q        <= '0;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      acc_q    <= acc_d;
      halted_q <= halted_d;
      if (cfg_we_i) begin
        start_addr_q <= cfg_wdata_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_print_q  <= res_print_d;
    res_used_q   <= res_used_d;
    if (in_fire) begin
      data_q <= in_i.data.data_word;
    end
    if (state_q == S_DEC) begin
      op_q  <= w_op;
      wlo_q <= w[12:0];
      bad_q <= !(w_in_rng && w_op_ok);
    end
    if (state_q == S_OPER) begin
      loc_q <= wrap_tbl[rem13[AddrW-1:0]];
    end
    if (state_q == S_OUT && out_free) begin
      out_q.status          <= res_status_q;
      out_q.print_value     <= res_print_q;
      out_q.input_used      <= res_used_q;
      out_q.program_counter <= AddrW'(pc_q);
      out_q.acc_value       <= acc_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  dam_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (mem_rdata),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

endmodule

// ===== dv/dam_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_checker
// Watches the command and result channels of the decimal accumulator machine,
// keeps its own copy of memory, pc, accumulator and halt flag, and compares
// every result transaction field by field against the predicted one.
// ----------------------------------------------------------------------------
module dam_checker #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dam_pkg::AddrW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  dam_pkg::in_item_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  dam_pkg::out_item_t        out_data_i,
  output int                        err_count_o,
  output int                        pending_o,
  output int                        checked_o
);
  import dam_pkg::*;

  logic [DataW-1:0] mem_img [MEM_WORDS];
  logic [AddrW-1:0] pc_q;
  logic [AddrW-1:0] start_q;
  logic [DataW-1:0] acc_q;
  logic             halted_q;
  out_item_t        result_q [$];
  out_item_t        want;

  function automatic logic [AddrW-1:0] wrap_addr(int unsigned a);
    return AddrW'(a % MEM_WORDS);
  endfunction

  // signed divide, truncating toward zero; min / -1 wraps back to min
  function automatic logic [DataW-1:0] quot_trunc(logic [DataW-1:0] num,
                                                  logic [DataW-1:0] den);
    logic [DataW-1:0] mag_n, mag_d, q;
    mag_n = num[DataW-1] ? -num : num;
    mag_d = den[DataW-1] ? -den : den;
    q = mag_n / mag_d;
    return (num[DataW-1] ^ den[DataW-1]) ? -q : q;
  endfunction

  function automatic out_item_t run_item(in_item_t it);
    out_item_t        r;
    logic [DataW-1:0] word, opnd;
    int unsigned      op;
    logic [AddrW-1:0] loc, pc_next;
    r = '0;
    r.status = StOk;
    case (it.cmd)
      CmdLoad: begin
        mem_img[wrap_addr(it.address)] = it.data_word;
        r.status = StLoaded;
      end
      CmdStart: begin
        pc_q = wrap_addr(start_q);
        acc_q = '0;
        halted_q = 1'b0;
      end
      CmdExec: begin
        if (halted_q) begin
          r.status = StHalt;
        end else begin
          word = mem_img[pc_q];
          op = word[DataW-1] ? 0 : word / 100;
          loc = wrap_addr(word % 100);
          opnd = mem_img[loc];
          pc_next = wrap_addr(pc_q + 1);
          case (op)
            OpRead: begin
              mem_img[loc] = it.data_word;
              r.input_used = 1'b1;
              pc_q = pc_next;
            end
            OpPrint: begin
              r.print_value = opnd;
              r.status = StPrint;
              pc_q = pc_next;
            end
            OpLoad: begin
              acc_q = opnd;
              pc_q = pc_next;
            end
            OpStore: begin
              mem_img[loc] = acc_q;
              pc_q = pc_next;
            end
            OpAdd: begin
              acc_q = acc_q + opnd;
              pc_q = pc_next;
            end
            OpSub: begin
              acc_q = acc_q - opnd;
              pc_q = pc_next;
            end
            OpDiv: begin
              if (opnd == '0) r.status = StDivZero;
              else acc_q = quot_trunc(acc_q, opnd);
              pc_q = pc_next;
            end
            OpMul: begin
              acc_q = acc_q * opnd;
              pc_q = pc_next;
            end
            OpBranch: pc_q = loc;
            OpBrNeg:  pc_q = acc_q[DataW-1] ? loc : pc_next;
            OpBrZero: pc_q = (acc_q == '0) ? loc : pc_next;
            OpHalt: begin
              halted_q = 1'b1;
              r.status = StHalt;
            end
            default: r.status = StBadOp;
          endcase
        end
      end
      default: ;
    endcase
    r.program_counter = pc_q;
    r.acc_value = acc_q;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      err_count_o++;
      $display("%0t dam_checker: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (mem_img[i]) mem_img[i] = '0;
      pc_q = '0;
      start_q = '0;
      acc_q = '0;
      halted_q = 1'b0;
      result_q.delete();
      err_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) start_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) result_q.push_back(run_item(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          err_count_o++;
          $display("%0t dam_checker: result transaction with none expected, status %0d",
                   $time, out_data_i.status);
        end else begin
          want = result_q.pop_front();
          checked_o++;
          check_field("status", want.status, out_data_i.status);
          check_field("print_value", longint'(want.print_value),
                      longint'(out_data_i.print_value));
          check_field("input_used", want.input_used, out_data_i.input_used);
          check_field("program_counter", want.program_counter,
                      out_data_i.program_counter);
          check_field("acc_value", longint'(want.acc_value),
                      longint'(out_data_i.acc_value));
        end
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== dv/tb_decimal_accumulator_machine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_accumulator_machine
// Stimulus and verdict for the decimal accumulator machine: a directed
// program touching every opcode and corner, then random programs loaded,
// started and stepped with random gaps and output stalls; dam_checker
// predicts and compares.
// ----------------------------------------------------------------------------
module tb_decimal_accumulator_machine;
  import dam_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int RandItems = 850;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [AddrW-1:0]     cfg_wdata;
  int                   err_count, chk_pending, chk_checked;
  int                   sent, runs, cfg_writes;
  logic [AddrW-1:0]     start_shadow;
  bit                   calm;

  dam_stream_if #(.T(in_item_t))  in_if ();
  dam_stream_if #(.T(out_item_t)) out_if ();

  decimal_accumulator_machine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  dam_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .err_count_o (err_count),
    .pending_o   (chk_pending),
    .checked_o   (chk_checked)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [DataW-1:0] instr(int op, int opnd);
    return DataW'(op * 100 + opnd);
  endfunction

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return DataW'($urandom_range(0, 300));
      6: return -DataW'($urandom_range(1, 300));
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // mostly well-formed instructions; branches land inside the loaded program
  function automatic logic [DataW-1:0] rand_instr(int base, int len);
    int k, op;
    if ($urandom_range(0, 99) < 10) begin
      case ($urandom_range(0, 3))
        0: return $urandom;
        1: return {1'b1, 31'($urandom)};
        2: return instr($urandom_range(0, 9), $urandom_range(0, 99));
        default: return instr($urandom_range(44, 99), $urandom_range(0, 99));
      endcase
    end
    k = $urandom_range(0, 22);
    case (k / 2)
      0:  op = OpRead;
      1:  op = OpPrint;
      2:  op = OpLoad;
      3:  op = OpStore;
      4:  op = OpAdd;
      5:  op = OpSub;
      6:  op = OpDiv;
      7:  op = OpMul;
      8:  op = OpBranch;
      9:  op = OpBrNeg;
      10: op = OpBrZero;
      default: op = OpHalt;
    endcase
    if (op == OpBranch || op == OpBrNeg || op == OpBrZero)
      return instr(op, (base + $urandom_range(0, len - 1)) % 100);
    return instr(op, $urandom_range(0, 99));
  endfunction

  task automatic push_item(input logic [1:0] cmd, input int unsigned addr,
                           input logic [DataW-1:0] data);
    in_item_t it;
    int       gap;
    it.cmd = cmd;
    it.address = addr[AddrW-1:0];
    it.data_word = data;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.data = it;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  // wait until every expected result transaction has come back
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (chk_pending == 0);
  endtask

  task automatic write_start(input logic [AddrW-1:0] v);
    settle();
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    start_shadow = v;
    cfg_writes++;
  endtask

  initial begin
    int hold, r;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        out_if.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_if.ready = 1'b1;
          hold = $urandom_range(0, 12);
        end else if (r < 92) begin
          out_if.ready = 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_if.ready = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    int base, len, steps, a, dir_count;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    sent = 0;
    runs = 0;
    cfg_writes = 0;
    start_shadow = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed program: starts at the last word so the pc wraps to 0
    write_start(AddrW'(99));
    push_item(CmdLoad, 127, 32'h8000_0000);       // lands on word 27
    push_item(CmdLoad, 99, instr(OpRead, 28));
    push_item(CmdLoad, 0, instr(OpLoad, 27));
    push_item(CmdLoad, 1, instr(OpDiv, 28));      // min / -1
    push_item(CmdLoad, 2, instr(OpDiv, 29));      // divide by zero
    push_item(CmdLoad, 3, instr(OpPrint, 27));
    push_item(CmdLoad, 4, instr(OpMul, 28));
    push_item(CmdLoad, 5, instr(OpAdd, 28));
    push_item(CmdLoad, 6, instr(OpSub, 28));
    push_item(CmdLoad, 7, instr(OpStore, 30));
    push_item(CmdLoad, 8, instr(OpBrZero, 11));
    push_item(CmdLoad, 9, instr(OpBrNeg, 12));
    push_item(CmdLoad, 12, instr(OpBranch, 13));
    push_item(CmdLoad, 13, 32'hFFFF_F000);        // negative word
    push_item(CmdStart, 0, '0);
    repeat (13) push_item(CmdExec, 0, 32'hFFFF_FFFF);
    push_item(CmdLoad, 13, instr(OpHalt, 0));
    push_item(CmdExec, 127, 32'h7FFF_FFFF);
    push_item(CmdExec, 0, '0);                    // executes while halted
    push_item(CmdUnused, 85, 32'h5A5A_A5A5);
    dir_count = sent;

    while (sent < dir_count + RandItems) begin
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 7))
          0: write_start('0);
          1: write_start(AddrW'(99));
          2: write_start(AddrW'(127));
          3: write_start(AddrW'($urandom_range(100, 127)));
          default: write_start(AddrW'($urandom_range(0, 99)));
        endcase
      end
      calm = ($urandom_range(0, 4) == 0);
      runs++;
      base = start_shadow % 100;
      len = $urandom_range(4, 16);
      for (int i = 0; i < len; i++) begin
        a = (base + i) % 100;
        if (a < 28 && $urandom_range(0, 1) == 1) a += 100;
        push_item(CmdLoad, a, rand_instr(base, len));
      end
      repeat ($urandom_range(2, 6)) push_item(CmdLoad, $urandom_range(0, 127), rand_value());
      push_item(CmdStart, $urandom_range(0, 127), $urandom);
      steps = $urandom_range(8, 40);
      for (int s = 0; s < steps; s++) begin
        case ($urandom_range(0, 19))
          0: push_item(CmdUnused, $urandom_range(0, 127), $urandom);
          1: push_item(CmdLoad, $urandom_range(0, 127), rand_value());
          2: push_item(CmdStart, $urandom_range(0, 127), $urandom);
          default: push_item(CmdExec, $urandom_range(0, 127), rand_value());
        endcase
      end
    end

    settle();
    repeat (50) @(posedge clk_i);
    $display("summary: %0d command transactions (%0d directed), %0d random programs",
             sent, dir_count, runs);
    $display("summary: %0d start-address writes, %0d result transactions checked",
             cfg_writes, chk_checked);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== decimal_accumulator_machine.f =====
rtl/dam_pkg.sv
rtl/dam_stream_if.sv
rtl/dam_mem.sv
rtl/dam_div.sv
rtl/decimal_accumulator_machine.sv
dv/dam_checker.sv
dv/tb_decimal_accumulator_machine.sv
